@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("forbidden condition");

`endif

@@ rtl/core/ffcu_pkg.sv @@
// Types and constants of the face field curl update block.
package ffcu_pkg;

  localparam int DW = 32;
  localparam int ONE_Q16 = 65536;
  localparam int KW = 17;
  localparam int CW = 31;
  localparam int IDX_W = 3;
  localparam int SIDE_CFG_W = 6;

  typedef enum logic [IDX_W-1:0] {
    REG_BLEND = 3'd0,
    REG_DT    = 3'd1,
    REG_INV_X = 3'd2,
    REG_INV_Y = 3'd3,
    REG_INV_Z = 3'd4,
    REG_SIDE  = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [KW-1:0] kappa;
    logic [CW-1:0] dt;
    logic [CW-1:0] inv_x;
    logic [CW-1:0] inv_y;
    logic [CW-1:0] inv_z;
  } coef_t;

  typedef struct packed {
    logic                 last;
    logic signed [DW-1:0] ex;
    logic signed [DW-1:0] ey;
    logic signed [DW-1:0] ez;
    logic signed [DW-1:0] ex_k;
    logic signed [DW-1:0] ey_k;
    logic signed [DW-1:0] ex_j;
    logic signed [DW-1:0] ez_j;
    logic signed [DW-1:0] ey_i;
    logic signed [DW-1:0] ez_i;
    logic signed [DW-1:0] old_x;
    logic signed [DW-1:0] old_y;
    logic signed [DW-1:0] old_z;
    logic signed [DW-1:0] cur_x;
    logic signed [DW-1:0] cur_y;
    logic signed [DW-1:0] cur_z;
  } item_t;

  // (a - b) * inv, full precision
  function automatic logic signed [DW+32:0] deriv_mul(input logic signed [DW-1:0] a,
                                                      input logic signed [DW-1:0] b,
                                                      input logic [CW-1:0] inv);
    logic signed [DW:0] diff;
    diff = $signed({a[DW-1], a}) - $signed({b[DW-1], b});
    return diff * $signed({1'b0, inv});
  endfunction

  function automatic logic signed [DW-1:0] sat_dw(input logic signed [DW+33:0] v);
    logic signed [DW+33:0] hi;
    logic signed [DW+33:0] lo;
    hi = (DW+34)'({1'b0, {(DW-1){1'b1}}});
    lo = -hi - (DW+34)'(1);
    if (v > hi) return {1'b0, {(DW-1){1'b1}}};
    if (v < lo) return {1'b1, {(DW-1){1'b0}}};
    return v[DW-1:0];
  endfunction

endpackage

@@ rtl/core/ffcu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ffcu_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/ffcu_fifo.sv @@
// Short queue of classified items between front and back.
module ffcu_fifo #(
  parameter int DEPTH = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ffcu_pkg::item_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output ffcu_pkg::item_t data_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  ffcu_pkg::item_t mem_q [DEPTH];
  logic [AW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == NW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + NW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/core/ffcu_front.sv @@
// Front end: position tracking, neighbour stores and interior classification.
module ffcu_front #(
  parameter int MAX_SIDE = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [ffcu_pkg::SIDE_CFG_W-1:0]   side_cfg_i,
  input  logic                              push_i,
  output logic                              full_o,
  input  logic                              grid_start_i,
  input  logic signed [ffcu_pkg::DW-1:0]    emf_x_i,
  input  logic signed [ffcu_pkg::DW-1:0]    emf_y_i,
  input  logic signed [ffcu_pkg::DW-1:0]    emf_z_i,
  input  logic signed [ffcu_pkg::DW-1:0]    old_face_x_i,
  input  logic signed [ffcu_pkg::DW-1:0]    old_face_y_i,
  input  logic signed [ffcu_pkg::DW-1:0]    old_face_z_i,
  input  logic signed [ffcu_pkg::DW-1:0]    cur_face_x_i,
  input  logic signed [ffcu_pkg::DW-1:0]    cur_face_y_i,
  input  logic signed [ffcu_pkg::DW-1:0]    cur_face_z_i,
  output logic                              q_push_o,
  output ffcu_pkg::item_t                   q_data_o,
  input  logic                              q_full_i
);

  localparam int DW    = ffcu_pkg::DW;
  localparam int PW    = $clog2(MAX_SIDE);
  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int CMPW  = ffcu_pkg::SIDE_CFG_W + 2;
  localparam logic [AW-1:0] SIDE_A = AW'(MAX_SIDE);

  typedef enum logic [1:0] {
    S_TAKE  = 2'b01,
    S_STORE = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic [PW-1:0] pos_i_q, pos_j_q, pos_k_q;
  logic [PW-1:0] i_c, j_c, k_c, i_n, j_n, k_n;
  logic [SW-1:0] side_c, lim_c, iw, jw, kw;
  logic accept, emit_c, last_c, leave;
  logic [AW-1:0] pidx_c, pidx_q;
  logic signed [DW-1:0] prev_x_q, prev_y_q;
  logic signed [DW-1:0] row_x_q [MAX_SIDE];
  logic signed [DW-1:0] row_z_q [MAX_SIDE];
  logic emit_q;
  ffcu_pkg::item_t hold_q;
  logic [2*DW-1:0] ram_rdata;

  assign accept = push_i && (state_q == S_TAKE);
  assign full_o = (state_q != S_TAKE);

  // effective side, clamped to [3, MAX_SIDE]
  always_comb begin
    if (CMPW'(side_cfg_i) < CMPW'(3)) begin
      side_c = SW'(3);
    end else if (CMPW'(side_cfg_i) > CMPW'(MAX_SIDE)) begin
      side_c = SW'(MAX_SIDE);
    end else begin
      side_c = SW'(side_cfg_i);
    end
  end

  assign i_c   = grid_start_i ? '0 : pos_i_q;
  assign j_c   = grid_start_i ? '0 : pos_j_q;
  assign k_c   = grid_start_i ? '0 : pos_k_q;
  assign iw    = SW'(i_c);
  assign jw    = SW'(j_c);
  assign kw    = SW'(k_c);
  assign lim_c = side_c - SW'(2);
  assign emit_c = (iw >= SW'(1)) && (iw <= lim_c) && (jw >= SW'(1)) && (jw <= lim_c)
               && (kw >= SW'(1)) && (kw <= lim_c);
  assign last_c = (iw == lim_c) && (jw == lim_c) && (kw == lim_c);
  assign pidx_c = AW'(j_c) * SIDE_A + AW'(k_c);

  // raster advance: k fastest, then j, then i
  always_comb begin
    i_n = i_c;
    j_n = j_c;
    k_n = k_c + PW'(1);
    if (kw + SW'(1) >= side_c) begin
      k_n = '0;
      if (jw + SW'(1) >= side_c) begin
        j_n = '0;
        i_n = (iw + SW'(1) >= side_c) ? '0 : i_c + PW'(1);
      end else begin
        j_n = j_c + PW'(1);
      end
    end
  end

  assign leave = !emit_q || !q_full_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_TAKE:  if (accept) state_d = S_STORE;
      S_STORE: if (leave) state_d = S_TAKE;
      default: state_d = S_TAKE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_TAKE;
      pos_i_q  <= '0;
      pos_j_q  <= '0;
      pos_k_q  <= '0;
      prev_x_q <= '0;
      prev_y_q <= '0;
      emit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        pos_i_q  <= i_n;
        pos_j_q  <= j_n;
        pos_k_q  <= k_n;
        prev_x_q <= emf_x_i;
        prev_y_q <= emf_y_i;
        emit_q   <= emit_c;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      row_x_q[k_c] <= emf_x_i;
      row_z_q[k_c] <= emf_z_i;
      pidx_q       <= pidx_c;
      hold_q.last  <= last_c;
      hold_q.ex    <= emf_x_i;
      hold_q.ey    <= emf_y_i;
      hold_q.ez    <= emf_z_i;
      hold_q.ex_k  <= prev_x_q;
      hold_q.ey_k  <= prev_y_q;
      hold_q.ex_j  <= row_x_q[k_c];
      hold_q.ez_j  <= row_z_q[k_c];
      hold_q.ey_i  <= '0;
      hold_q.ez_i  <= '0;
      hold_q.old_x <= old_face_x_i;
      hold_q.old_y <= old_face_y_i;
      hold_q.old_z <= old_face_z_i;
      hold_q.cur_x <= cur_face_x_i;
      hold_q.cur_y <= cur_face_y_i;
      hold_q.cur_z <= cur_face_z_i;
    end
  end

  // plane store: read on accept, write back the new EMFs next cycle
  ffcu_ram #(
    .WIDTH(2 * DW),
    .DEPTH(DEPTH)
  ) u_plane (
    .clk_i  (clk_i),
    .we_i   (state_q == S_STORE),
    .waddr_i(pidx_q),
    .wdata_i({hold_q.ey, hold_q.ez}),
    .re_i   (accept),
    .raddr_i(pidx_c),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    q_data_o      = hold_q;
    q_data_o.ey_i = ram_rdata[2*DW-1:DW];
    q_data_o.ez_i = ram_rdata[DW-1:0];
  end

  assign q_push_o = (state_q == S_STORE) && emit_q && !q_full_i;

endmodule

@@ rtl/core/ffcu_back.sv @@
// Back end: arithmetic pipeline stages A, B and C followed by an output register.
module ffcu_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ffcu_pkg::coef_t                coef_i,
  input  logic                           q_valid_i,
  input  ffcu_pkg::item_t                q_data_i,
  output logic                           q_pop_o,
  output logic                           empty_o,
  input  logic                           pop_i,
  output logic signed [ffcu_pkg::DW-1:0] new_face_x_o,
  output logic signed [ffcu_pkg::DW-1:0] new_face_y_o,
  output logic signed [ffcu_pkg::DW-1:0] new_face_z_o,
  output logic                           last_of_grid_o
);

  localparam int DW = ffcu_pkg::DW;
  localparam int KW = ffcu_pkg::KW;
  localparam int CW = ffcu_pkg::CW;
  localparam int PD = DW + 33;       // derivative product
  localparam int PB = DW + KW + 1;   // blend product
  localparam int BW = DW + 3;        // blend after shift

  logic en;
  logic va_q, vb_q, vc_q, vo_q;

  // stage A: products
  logic signed [PD-1:0] d_zy_q, d_yz_q, d_zx_q, d_xz_q, d_yx_q, d_xy_q;
  logic signed [PB-1:0] po_x_q, po_y_q, po_z_q, pc_x_q, pc_y_q, pc_z_q;
  logic [KW+CW-1:0] kdt_p_q;
  logic last_a_q;
  // stage B: curl, blend, kdt
  logic signed [DW:0] curl_x_q, curl_y_q, curl_z_q;
  logic signed [BW-1:0] bl_x_q, bl_y_q, bl_z_q;
  logic [CW-1:0] kdt_q;
  logic last_b_q;
  // stage C: curl times kdt
  logic signed [PD-1:0] cp_x_q, cp_y_q, cp_z_q;
  logic signed [BW-1:0] bl_xc_q, bl_yc_q, bl_zc_q;
  logic last_c_q;
  // output register
  logic signed [DW-1:0] out_x_q, out_y_q, out_z_q;
  logic last_o_q;

  logic [KW-1:0] kappa_c;
  logic signed [KW:0] w_old, w_cur;
  logic signed [DW-1:0] s_zy, s_yz, s_zx, s_xz, s_yx, s_xy;

  assign en      = !vo_q || pop_i;
  assign q_pop_o = en && q_valid_i;

  assign kappa_c = (coef_i.kappa > KW'(ffcu_pkg::ONE_Q16)) ? KW'(ffcu_pkg::ONE_Q16)
                                                           : coef_i.kappa;
  assign w_old = $signed({1'b0, KW'(ffcu_pkg::ONE_Q16) - kappa_c});
  assign w_cur = $signed({1'b0, kappa_c});

  assign s_zy = ffcu_pkg::sat_dw((PD+1)'(d_zy_q >>> 16));
  assign s_yz = ffcu_pkg::sat_dw((PD+1)'(d_yz_q >>> 16));
  assign s_zx = ffcu_pkg::sat_dw((PD+1)'(d_zx_q >>> 16));
  assign s_xz = ffcu_pkg::sat_dw((PD+1)'(d_xz_q >>> 16));
  assign s_yx = ffcu_pkg::sat_dw((PD+1)'(d_yx_q >>> 16));
  assign s_xy = ffcu_pkg::sat_dw((PD+1)'(d_xy_q >>> 16));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      va_q <= q_valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vo_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_zy_q   <= ffcu_pkg::deriv_mul(q_data_i.ez, q_data_i.ez_j, coef_i.inv_y);
      d_yz_q   <= ffcu_pkg::deriv_mul(q_data_i.ey, q_data_i.ey_k, coef_i.inv_z);
      d_zx_q   <= ffcu_pkg::deriv_mul(q_data_i.ez, q_data_i.ez_i, coef_i.inv_x);
      d_xz_q   <= ffcu_pkg::deriv_mul(q_data_i.ex, q_data_i.ex_k, coef_i.inv_z);
      d_yx_q   <= ffcu_pkg::deriv_mul(q_data_i.ey, q_data_i.ey_i, coef_i.inv_x);
      d_xy_q   <= ffcu_pkg::deriv_mul(q_data_i.ex, q_data_i.ex_j, coef_i.inv_y);
      po_x_q   <= w_old * q_data_i.old_x;
      po_y_q   <= w_old * q_data_i.old_y;
      po_z_q   <= w_old * q_data_i.old_z;
      pc_x_q   <= w_cur * q_data_i.cur_x;
      pc_y_q   <= w_cur * q_data_i.cur_y;
      pc_z_q   <= w_cur * q_data_i.cur_z;
      kdt_p_q  <= kappa_c * coef_i.dt;
      last_a_q <= q_data_i.last;

      curl_x_q <= (DW+1)'(s_zy) - (DW+1)'(s_yz);
      curl_y_q <= (DW+1)'(s_xz) - (DW+1)'(s_zx);
      curl_z_q <= (DW+1)'(s_yx) - (DW+1)'(s_xy);
      bl_x_q   <= BW'(((PB+1)'(po_x_q) + (PB+1)'(pc_x_q)) >>> 16);
      bl_y_q   <= BW'(((PB+1)'(po_y_q) + (PB+1)'(pc_y_q)) >>> 16);
      bl_z_q   <= BW'(((PB+1)'(po_z_q) + (PB+1)'(pc_z_q)) >>> 16);
      kdt_q    <= kdt_p_q[CW+15:16];
      last_b_q <= last_a_q;

      cp_x_q   <= curl_x_q * $signed({1'b0, kdt_q});
      cp_y_q   <= curl_y_q * $signed({1'b0, kdt_q});
      cp_z_q   <= curl_z_q * $signed({1'b0, kdt_q});
      bl_xc_q  <= bl_x_q;
      bl_yc_q  <= bl_y_q;
      bl_zc_q  <= bl_z_q;
      last_c_q <= last_b_q;

      out_x_q  <= ffcu_pkg::sat_dw((PD+1)'(bl_xc_q) + (PD+1)'(cp_x_q >>> 16));
      out_y_q  <= ffcu_pkg::sat_dw((PD+1)'(bl_yc_q) + (PD+1)'(cp_y_q >>> 16));
      out_z_q  <= ffcu_pkg::sat_dw((PD+1)'(bl_zc_q) + (PD+1)'(cp_z_q >>> 16));
      last_o_q <= last_c_q;
    end
  end

  assign empty_o        = !vo_q;
  assign new_face_x_o   = out_x_q;
  assign new_face_y_o   = out_y_q;
  assign new_face_z_o   = out_z_q;
  assign last_of_grid_o = last_o_q;

endmodule

@@ rtl/core/face_field_curl_update.sv @@
// Top level of the face field curl update block.
//
// Input channel: push_i/full_o carry one grid point per beat, raster order
// with k fastest. grid_start_i marks point (0,0,0) of a new cube.
// Result channel: empty_o/pop_i, one beat per interior point, holding the
// blended curl update and a flag on the last interior point of the cube.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i at once.
// The front end takes a new point only after the last one's plane store
// read and write-back. From accept, a point passes the front-end hold
// register, the queue, back stages A, B and C and the output register.
// A two-entry queue separates front and back; when the receiver does not
// pop, the back pipeline halts, the queue fills and full_o stays high.
// Reset empties all queues, zeroes position and neighbour registers and
// loads the register defaults; line and plane stores are not cleared.
module face_field_curl_update #(
  parameter int MAX_SIDE = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ffcu_pkg::IDX_W-1:0]     cfg_idx_i,
  input  logic [ffcu_pkg::CW-1:0]        cfg_data_i,
  input  logic                           push_i,
  output logic                           full_o,
  input  logic                           grid_start_i,
  input  logic signed [ffcu_pkg::DW-1:0] emf_x_i,
  input  logic signed [ffcu_pkg::DW-1:0] emf_y_i,
  input  logic signed [ffcu_pkg::DW-1:0] emf_z_i,
  input  logic signed [ffcu_pkg::DW-1:0] old_face_x_i,
  input  logic signed [ffcu_pkg::DW-1:0] old_face_y_i,
  input  logic signed [ffcu_pkg::DW-1:0] old_face_z_i,
  input  logic signed [ffcu_pkg::DW-1:0] cur_face_x_i,
  input  logic signed [ffcu_pkg::DW-1:0] cur_face_y_i,
  input  logic signed [ffcu_pkg::DW-1:0] cur_face_z_i,
  output logic                           empty_o,
  input  logic                           pop_i,
  output logic signed [ffcu_pkg::DW-1:0] new_face_x_o,
  output logic signed [ffcu_pkg::DW-1:0] new_face_y_o,
  output logic signed [ffcu_pkg::DW-1:0] new_face_z_o,
  output logic                           last_of_grid_o
);

  ffcu_pkg::coef_t coef_q;
  logic [ffcu_pkg::SIDE_CFG_W-1:0] side_q;
  logic q_push, q_full, q_pop, q_valid;
  ffcu_pkg::item_t q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.kappa <= ffcu_pkg::KW'(ffcu_pkg::ONE_Q16);
      coef_q.dt    <= ffcu_pkg::CW'(ffcu_pkg::ONE_Q16);
      coef_q.inv_x <= ffcu_pkg::CW'(ffcu_pkg::ONE_Q16);
      coef_q.inv_y <= ffcu_pkg::CW'(ffcu_pkg::ONE_Q16);
      coef_q.inv_z <= ffcu_pkg::CW'(ffcu_pkg::ONE_Q16);
      side_q       <= ffcu_pkg::SIDE_CFG_W'(32);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ffcu_pkg::REG_BLEND: coef_q.kappa <= cfg_data_i[ffcu_pkg::KW-1:0];
        ffcu_pkg::REG_DT:    coef_q.dt    <= cfg_data_i;
        ffcu_pkg::REG_INV_X: coef_q.inv_x <= cfg_data_i;
        ffcu_pkg::REG_INV_Y: coef_q.inv_y <= cfg_data_i;
        ffcu_pkg::REG_INV_Z: coef_q.inv_z <= cfg_data_i;
        ffcu_pkg::REG_SIDE:  side_q       <= cfg_data_i[ffcu_pkg::SIDE_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  ffcu_front #(
    .MAX_SIDE(MAX_SIDE)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .side_cfg_i  (side_q),
    .push_i      (push_i),
    .full_o      (full_o),
    .grid_start_i(grid_start_i),
    .emf_x_i     (emf_x_i),
    .emf_y_i     (emf_y_i),
    .emf_z_i     (emf_z_i),
    .old_face_x_i(old_face_x_i),
    .old_face_y_i(old_face_y_i),
    .old_face_z_i(old_face_z_i),
    .cur_face_x_i(cur_face_x_i),
    .cur_face_y_i(cur_face_y_i),
    .cur_face_z_i(cur_face_z_i),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata),
    .q_full_i    (q_full)
  );

  ffcu_fifo #(
    .DEPTH(2)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_rdata)
  );

  ffcu_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .coef_i        (coef_q),
    .q_valid_i     (q_valid),
    .q_data_i      (q_rdata),
    .q_pop_o       (q_pop),
    .empty_o       (empty_o),
    .pop_i         (pop_i),
    .new_face_x_o  (new_face_x_o),
    .new_face_y_o  (new_face_y_o),
    .new_face_z_o  (new_face_z_o),
    .last_of_grid_o(last_of_grid_o)
  );

endmodule

@@ rtl/core/ffcu_checker.sv @@
// Port-level checks for the face field curl update block, bound to the top.
`include "assert_macros.svh"

module ffcu_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           push_i,
  input logic                           full_o,
  input logic                           empty_o,
  input logic                           pop_i,
  input logic signed [ffcu_pkg::DW-1:0] new_face_x_o,
  input logic                           last_of_grid_o
);

  // full_o is raised while the front end holds an accepted point
  `ASSERT_CLK(a_busy_after_accept, clk_i, rst_ni, (push_i && !full_o) |=> full_o)

  // nothing waits right after reset
  `ASSERT_CLK(a_empty_after_reset, clk_i, rst_ni, $rose(rst_ni) |-> empty_o)

  // a held result stays put
  `ASSERT_NEVER(a_held_result_moves, clk_i, rst_ni,
    $past(!empty_o && !pop_i) && $past(rst_ni) &&
    (empty_o || !$stable(new_face_x_o) || !$stable(last_of_grid_o)))

endmodule

bind face_field_curl_update ffcu_checker u_ffcu_checker (.*);

@@ dv/tb_face_field_curl_update.sv @@
// Self-checking testbench for the face field curl update block.
module tb_face_field_curl_update;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW = ffcu_pkg::DW;
  localparam int CW = ffcu_pkg::CW;
  localparam int IDX_W = ffcu_pkg::IDX_W;
  localparam int MAXS = 32;
  localparam int GAP_MAX = 12;
  localparam int DRAIN = 20;
  localparam longint CYCLE_LIMIT = 1000000;

  typedef struct {
    logic                 start;
    logic signed [DW-1:0] emf [3];
    logic signed [DW-1:0] old_f [3];
    logic signed [DW-1:0] cur_f [3];
  } point_t;

  typedef struct {
    logic signed [DW-1:0] face [3];
    logic                 last;
  } face_upd_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [IDX_W-1:0] cfg_idx_i;
  logic [CW-1:0] cfg_data_i;
  logic push_i, full_o, grid_start_i;
  logic signed [DW-1:0] emf_x_i, emf_y_i, emf_z_i;
  logic signed [DW-1:0] old_face_x_i, old_face_y_i, old_face_z_i;
  logic signed [DW-1:0] cur_face_x_i, cur_face_y_i, cur_face_z_i;
  logic empty_o, pop_i;
  logic signed [DW-1:0] new_face_x_o, new_face_y_o, new_face_z_o;
  logic last_of_grid_o;

  face_field_curl_update uut (.*);

  // predictor copy of registers and neighbour stores
  longint kappa_r, dt_r, inv_r [3];
  int side_r;
  longint prev_x, prev_y;
  longint row_x [MAXS], row_z [MAXS];
  longint plane_y [MAXS*MAXS], plane_z [MAXS*MAXS];
  int pos_i, pos_j, pos_k;

  point_t pend_pts [$];
  face_upd_t upd_q [$];
  point_t on_bus;
  int gap_left, stall_left;
  bit calm_in, calm_out;
  int n_fail, n_pts, n_upd, n_lasts, n_rand;
  longint cycles;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint sat_q(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint slope(longint a, longint b, longint inv);
    return sat_q(((a - b) * inv) >>> 16);
  endfunction

  function automatic longint blend_out(longint o, longint c, longint curl, longint kap,
                                       longint kdt);
    longint bl;
    bl = ((65536 - kap) * o + kap * c) >>> 16;
    return sat_q(bl + ((curl * kdt) >>> 16));
  endfunction

  task automatic predict_point(point_t p);
    int s, i, j, k, pidx;
    longint ex, ey, ez, exk, eyk, exj, ezj, eyi, ezi, kap, kdt;
    longint curl [3];
    face_upd_t u;
    s = side_r < 3 ? 3 : (side_r > MAXS ? MAXS : side_r);
    if (p.start) begin
      pos_i = 0; pos_j = 0; pos_k = 0;
    end
    i = pos_i; j = pos_j; k = pos_k;
    pidx = j * MAXS + k;
    ex = p.emf[0]; ey = p.emf[1]; ez = p.emf[2];
    exk = prev_x; eyk = prev_y;
    exj = row_x[k]; ezj = row_z[k];
    eyi = plane_y[pidx]; ezi = plane_z[pidx];
    prev_x = ex; prev_y = ey;
    row_x[k] = ex; row_z[k] = ez;
    plane_y[pidx] = ey; plane_z[pidx] = ez;
    if (i >= 1 && i <= s-2 && j >= 1 && j <= s-2 && k >= 1 && k <= s-2) begin
      curl[0] = slope(ez, ezj, inv_r[1]) - slope(ey, eyk, inv_r[2]);
      curl[1] = slope(ex, exk, inv_r[2]) - slope(ez, ezi, inv_r[0]);
      curl[2] = slope(ey, eyi, inv_r[0]) - slope(ex, exj, inv_r[1]);
      kap = kappa_r > 65536 ? 65536 : kappa_r;
      kdt = (kap * dt_r) >>> 16;
      for (int f = 0; f < 3; f++)
        u.face[f] = DW'(blend_out(p.old_f[f], p.cur_f[f], curl[f], kap, kdt));
      u.last = (i == s-2 && j == s-2 && k == s-2);
      upd_q.push_back(u);
    end
    if (k + 1 >= s) begin
      k = 0;
      if (j + 1 >= s) begin
        j = 0;
        i = (i + 1 >= s) ? 0 : i + 1;
      end else begin
        j++;
      end
    end else begin
      k++;
    end
    pos_i = i; pos_j = j; pos_k = k;
  endtask

  // input side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push_i <= 1'b0;
      gap_left <= 0;
    end else begin
      if (push_i && !full_o) begin
        predict_point(on_bus);
        n_pts++;
      end
      if (!push_i || !full_o) begin
        if (gap_left > 0) begin
          push_i <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pend_pts.size() > 0) begin
          on_bus = pend_pts.pop_front();
          push_i <= 1'b1;
          grid_start_i <= on_bus.start;
          emf_x_i <= on_bus.emf[0]; emf_y_i <= on_bus.emf[1]; emf_z_i <= on_bus.emf[2];
          old_face_x_i <= on_bus.old_f[0]; old_face_y_i <= on_bus.old_f[1];
          old_face_z_i <= on_bus.old_f[2];
          cur_face_x_i <= on_bus.cur_f[0]; cur_face_y_i <= on_bus.cur_f[1];
          cur_face_z_i <= on_bus.cur_f[2];
          if ($urandom_range(0, 99) == 0) calm_in = ~calm_in;
          gap_left <= calm_in ? 0 : $urandom_range(0, GAP_MAX);
        end else begin
          push_i <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop_i <= 1'b0;
      stall_left <= 0;
    end else begin
      if (pop_i && !empty_o) begin
        face_upd_t e;
        n_upd++;
        if (upd_q.size() == 0) begin
          $error("unexpected beat on result port");
          n_fail++;
        end else begin
          e = upd_q.pop_front();
          if (new_face_x_o !== e.face[0]) begin
            $error("new_face_x exp %0d got %0d", e.face[0], new_face_x_o); n_fail++;
          end
          if (new_face_y_o !== e.face[1]) begin
            $error("new_face_y exp %0d got %0d", e.face[1], new_face_y_o); n_fail++;
          end
          if (new_face_z_o !== e.face[2]) begin
            $error("new_face_z exp %0d got %0d", e.face[2], new_face_z_o); n_fail++;
          end
          if (last_of_grid_o !== e.last) begin
            $error("last_of_grid exp %0b got %0b", e.last, last_of_grid_o); n_fail++;
          end
          if (e.last) n_lasts++;
        end
        if ($urandom_range(0, 49) == 0) calm_out = ~calm_out;
        if (!calm_out) begin
          stall_left <= $urandom_range(0, GAP_MAX);
          if ($urandom_range(0, 1)) pop_i <= 1'b0;
        end
      end else if (stall_left > 0) begin
        pop_i <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        pop_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d beats outstanding", upd_q.size());
      $display("face_field_curl_update verification failed");
      $finish;
    end
  end

  task automatic write_reg(ffcu_pkg::reg_idx_e r, logic [CW-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= r;
    cfg_data_i <= v;
    case (r)
      ffcu_pkg::REG_BLEND: kappa_r = v & 17'h1ffff;
      ffcu_pkg::REG_DT:    dt_r = v;
      ffcu_pkg::REG_INV_X: inv_r[0] = v;
      ffcu_pkg::REG_INV_Y: inv_r[1] = v;
      ffcu_pkg::REG_INV_Z: inv_r[2] = v;
      ffcu_pkg::REG_SIDE:  side_r = v & 6'h3f;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all(logic [16:0] kap, logic [CW-1:0] dt, logic [CW-1:0] ix,
                           logic [CW-1:0] iy, logic [CW-1:0] iz, logic [5:0] s);
    write_reg(ffcu_pkg::REG_BLEND, kap);
    write_reg(ffcu_pkg::REG_DT, dt);
    write_reg(ffcu_pkg::REG_INV_X, ix);
    write_reg(ffcu_pkg::REG_INV_Y, iy);
    write_reg(ffcu_pkg::REG_INV_Z, iz);
    write_reg(ffcu_pkg::REG_SIDE, s);
    @(posedge clk_i);
  endtask

  task automatic drain_all();
    while (pend_pts.size() != 0 || push_i || upd_q.size() != 0) @(posedge clk_i);
    // points off the interior still pass through the front end
    repeat (DRAIN) @(posedge clk_i);
  endtask

  function automatic logic [DW-1:0] field_val();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3, 4, 5: return $urandom;
      default: return $urandom_range(0, 32'h1fffff) - 32'h100000;
    endcase
  endfunction

  function automatic logic [CW-1:0] coef_val();
    case ($urandom_range(0, 7))
      0: return 31'h0;
      1: return 31'h7fffffff;
      2, 3: return $urandom & 31'h7fffffff;
      default: return $urandom_range(0, 31'h3ffff);
    endcase
  endfunction

  task automatic queue_points(int count, bit first_start);
    point_t p;
    for (int n = 0; n < count; n++) begin
      p.start = first_start && n == 0;
      for (int f = 0; f < 3; f++) begin
        p.emf[f] = field_val();
        p.old_f[f] = field_val();
        p.cur_f[f] = field_val();
      end
      pend_pts.push_back(p);
    end
  endtask

  initial begin
    logic [DW-1:0] corner [7];
    logic [16:0] kap;
    logic [5:0] s;
    int eff, vol, len;
    point_t p;
    corner = '{32'h0, 32'hffffffff, 32'h7fffffff, 32'h80000000, 32'h1,
               32'h55555555, 32'haaaaaaaa};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    push_i = 1'b0; grid_start_i = 1'b0; pop_i = 1'b0;
    {emf_x_i, emf_y_i, emf_z_i} = '0;
    {old_face_x_i, old_face_y_i, old_face_z_i} = '0;
    {cur_face_x_i, cur_face_y_i, cur_face_z_i} = '0;
    n_fail = 0; n_pts = 0; n_upd = 0; n_lasts = 0; n_rand = 0; cycles = 0;
    calm_in = 0; calm_out = 0;
    kappa_r = 65536; dt_r = 65536; inv_r = '{65536, 65536, 65536}; side_r = 32;
    prev_x = 0; prev_y = 0; pos_i = 0; pos_j = 0; pos_k = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: smallest cube, field corners rotated across fields
    write_all(17'd65536, 31'd65536, 31'd65536, 31'd65536, 31'd65536, 6'd3);
    for (int n = 0; n < 27; n++) begin
      p.start = n == 0;
      for (int f = 0; f < 3; f++) begin
        p.emf[f] = corner[(n + f) % 7];
        p.old_f[f] = corner[(n + f + 2) % 7];
        p.cur_f[f] = corner[(n + 2*f + 4) % 7];
      end
      pend_pts.push_back(p);
    end
    drain_all();

    // side above range clamps to the widest cube; run into the first interior row
    write_all(17'd131071, 31'h7fffffff, 31'd4096, 31'd65536, 31'd300, 6'd63);
    queue_points(MAXS*MAXS + 2*MAXS, 1);
    drain_all();

    while (n_rand < 150) begin
      case ($urandom_range(0, 3))
        0: kap = 17'd0;
        1: kap = 17'd65536;
        2: kap = $urandom_range(65537, 131071);
        default: kap = $urandom_range(0, 65536);
      endcase
      s = $urandom_range(0, 9) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 6);
      write_all(kap, coef_val(), coef_val(), coef_val(), coef_val(), s);
      eff = s < 3 ? 3 : s;
      vol = eff * eff * eff;
      for (int c = $urandom_range(1, 3); c > 0; c--) begin
        // mostly whole cubes, some cut short; whole cubes but the last may go without a start mark
        len = $urandom_range(0, 5) == 0 ? $urandom_range(1, vol - 1) : vol;
        queue_points(len, c == 1 || len != vol || $urandom_range(0, 1));
        n_rand += len;
      end
      drain_all();
    end

    $display("%0d grid points sent, %0d face updates checked, %0d cube ends seen",
             n_pts, n_upd, n_lasts);
    if (n_fail == 0) begin
      $display("face_field_curl_update verification clean");
    end else begin
      $display("face_field_curl_update verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/ffcu_pkg.sv
rtl/core/ffcu_ram.sv
rtl/core/ffcu_fifo.sv
rtl/core/ffcu_front.sv
rtl/core/ffcu_back.sv
rtl/core/face_field_curl_update.sv
rtl/core/ffcu_checker.sv
dv/tb_face_field_curl_update.sv
